[rtl/core/bb3_pkg.sv]
`timescale 1ns / 1ps

package bb3_pkg;

  localparam int PIX_W         = 8;
  localparam int CFG_WIDTH_W   = 11;
  localparam int CFG_HEIGHT_W  = 13;
  localparam int OUT_ROW_W     = 12;
  localparam int OUT_COL_W     = 10;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;
  localparam int SUM_W         = 12;
  localparam int COUNT_W       = 4;
  localparam int DIVIDEND_W    = 13;
  localparam int RECIP_W       = 20;
  localparam int RECIP_SHIFT   = 20;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [CFG_WIDTH_W-1:0]  RESET_IMAGE_WIDTH  = 11'd1024;
  localparam logic [CFG_HEIGHT_W-1:0] RESET_IMAGE_HEIGHT = 13'd1;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  localparam int RGB_W = $bits(rgb_t);

  typedef struct packed {
    logic [PIX_W-1:0] pixel_red;
    logic [PIX_W-1:0] pixel_green;
    logic [PIX_W-1:0] pixel_blue;
  } pixel_word_t;

  typedef struct packed {
    logic [PIX_W-1:0]     blurred_red;
    logic [PIX_W-1:0]     blurred_green;
    logic [PIX_W-1:0]     blurred_blue;
    logic [OUT_ROW_W-1:0] out_row;
    logic [OUT_COL_W-1:0] out_column;
    logic                 last_of_run;
    logic                 frame_end;
  } result_word_t;

  // ceil(2^20 / (2*n)); exact quotients for every dividend the window can produce.
  function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    unique case (n)
      4'd1:    r = 20'd524288;
      4'd2:    r = 20'd262144;
      4'd3:    r = 20'd174763;
      4'd4:    r = 20'd131072;
      4'd5:    r = 20'd104858;
      4'd6:    r = 20'd87382;
      4'd7:    r = 20'd74899;
      4'd8:    r = 20'd65536;
      4'd9:    r = 20'd58255;
      default: r = 20'd524288;
    endcase
    return r;
  endfunction

  // Rounded mean floor((2*sum + n) / (2*n)) by reciprocal multiplication.
  function automatic logic [PIX_W-1:0] round_mean(input logic [SUM_W-1:0]   sum,
                                                  input logic [COUNT_W-1:0] n);
    logic [DIVIDEND_W-1:0]         v;
    logic [DIVIDEND_W+RECIP_W-1:0] prod;
    v    = {sum, 1'b0} + DIVIDEND_W'(n);
    prod = (DIVIDEND_W + RECIP_W)'(v) * (DIVIDEND_W + RECIP_W)'(recip(n));
    return prod[RECIP_SHIFT +: PIX_W];
  endfunction

endpackage

[rtl/core/bb3_ram.sv]
`timescale 1ns / 1ps

module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/box_blur_3x3_rgb_top.sv]
`timescale 1ns / 1ps

// 3x3 box blur over an RGB pixel stream in raster order. Each pixel word yields
// zero to four result words: the centre one row and one column behind it, the
// right-edge centre at a row end, and in the last row that row's own centres.
// Each result is the rounded-half-up mean of the in-image pixels of its 3x3
// neighbourhood, so edges and corners average fewer pixels. The two previous
// rows live in two simple dual-port RAMs of MAX_WIDTH entries with a registered
// read. Each pixel first reads and updates the row stores and the window, then
// each of its result words passes through the shared averaging unit (window
// sum, then a reciprocal multiply) before the next pixel is accepted. That
// pixel is accepted while the last result word still waits. Write image_width
// and image_height over the APB port (byte addresses 0 and 4) only while the
// block is idle.

module box_blur_3x3_rgb_top
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_ready,
  input  pixel_word_t           pixel_word,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_word_t          result_word,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WD_W  = ($clog2(MAX_WIDTH + 1) > CFG_WIDTH_W) ?
                         $clog2(MAX_WIDTH + 1) : CFG_WIDTH_W;
  localparam int HD_W  = ($clog2(MAX_HEIGHT + 1) > CFG_HEIGHT_W) ?
                         $clog2(MAX_HEIGHT + 1) : CFG_HEIGHT_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_SUM  = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

  state_t state;

  logic [CFG_WIDTH_W-1:0]  image_width;
  logic [CFG_HEIGHT_W-1:0] image_height;
  logic [WD_W-1:0]         width_eff;
  logic [HD_W-1:0]         height_eff;

  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] column_count;
  logic             col_end_now;
  logic             last_row_now;
  logic             accept;

  rgb_t             item_pixel;
  logic [ROW_W-1:0] item_row;
  logic [COL_W-1:0] item_col;
  logic             item_col_end;
  logic             item_last_row;

  logic [RGB_W-1:0] older_rd;
  logic [RGB_W-1:0] prev_rd;
  logic             store_we;

  rgb_t window [0:8];

  logic [3:0] pending;
  logic [3:0] low_bit;
  logic [1:0] kind;
  logic [2:0] row_ok;
  logic [2:0] col_ok;
  logic [8:0] incl;
  logic [SUM_W-1:0] acc_red;
  logic [SUM_W-1:0] acc_green;
  logic [SUM_W-1:0] acc_blue;

  logic [SUM_W-1:0]   sum_red;
  logic [SUM_W-1:0]   sum_green;
  logic [SUM_W-1:0]   sum_blue;
  logic [COUNT_W-1:0] sum_count;
  logic [ROW_W-1:0]   sum_row;
  logic [COL_W-1:0]   sum_col;
  logic               sum_last;
  logic               sum_frame_end;

  logic result_load;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_IMAGE_WIDTH;
      image_height <= RESET_IMAGE_HEIGHT;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[CFG_HEIGHT_W-1:0];
        default:          image_width  <= image_width;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    priority if (image_width == '0) begin
      width_eff = WD_W'(1);
    end else if (WD_W'(image_width) > WD_W'(MAX_WIDTH)) begin
      width_eff = WD_W'(MAX_WIDTH);
    end else begin
      width_eff = WD_W'(image_width);
    end
    priority if (image_height == '0) begin
      height_eff = HD_W'(1);
    end else if (HD_W'(image_height) > HD_W'(MAX_HEIGHT)) begin
      height_eff = HD_W'(MAX_HEIGHT);
    end else begin
      height_eff = HD_W'(image_height);
    end
  end

  assign col_end_now  = (WD_W'(column_count) + WD_W'(1)) >= width_eff;
  assign last_row_now = (HD_W'(row_count) + HD_W'(1)) >= height_eff;
  assign pixel_ready  = (state == S_IDLE);
  assign accept       = pixel_valid && pixel_ready;

  // Row stores.
  assign store_we = (state == S_LOAD);

  bb3_ram #(
    .WIDTH (RGB_W),
    .DEPTH (MAX_WIDTH)
  ) u_older_row (
    .clk   (clk),
    .we    (store_we),
    .waddr (item_col),
    .wdata (prev_rd),
    .raddr (column_count),
    .rdata (older_rd)
  );

  bb3_ram #(
    .WIDTH (RGB_W),
    .DEPTH (MAX_WIDTH)
  ) u_previous_row (
    .clk   (clk),
    .we    (store_we),
    .waddr (item_col),
    .wdata (item_pixel),
    .raddr (column_count),
    .rdata (prev_rd)
  );

  // Averaging unit: window selection and sums for the current result.
  always_comb begin
    priority if (pending[0]) begin
      low_bit = 4'b0001;
      kind    = 2'd0;
    end else if (pending[1]) begin
      low_bit = 4'b0010;
      kind    = 2'd1;
    end else if (pending[2]) begin
      low_bit = 4'b0100;
      kind    = 2'd2;
    end else begin
      low_bit = 4'b1000;
      kind    = 2'd3;
    end
    row_ok[2] = 1'b1;
    row_ok[1] = (item_row != '0);
    row_ok[0] = (item_row > ROW_W'(1)) && !kind[1];
    col_ok[2] = 1'b1;
    col_ok[1] = (item_col != '0);
    col_ok[0] = (item_col > COL_W'(1)) && !kind[0];
    acc_red   = '0;
    acc_green = '0;
    acc_blue  = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        incl[i*3+j] = row_ok[i] && col_ok[j];
        if (incl[i*3+j]) begin
          acc_red   = acc_red   + SUM_W'(window[i*3+j].red);
          acc_green = acc_green + SUM_W'(window[i*3+j].green);
          acc_blue  = acc_blue  + SUM_W'(window[i*3+j].blue);
        end
      end
    end
  end

  assign result_load = (state == S_DIV) && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      row_count    <= '0;
      column_count <= '0;
      pending      <= '0;
      result_valid <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        window[k] <= '0;
      end
    end else begin
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (col_end_now) begin
              column_count <= '0;
              row_count    <= last_row_now ? '0 : row_count + ROW_W'(1);
            end else begin
              column_count <= column_count + COL_W'(1);
            end
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            window[i*3+0] <= window[i*3+1];
            window[i*3+1] <= window[i*3+2];
          end
          window[2] <= rgb_t'(older_rd);
          window[5] <= rgb_t'(prev_rd);
          window[8] <= item_pixel;
          pending <= {item_last_row && item_col_end,
                      item_last_row && (item_col != '0),
                      (item_row != '0) && item_col_end,
                      (item_row != '0) && (item_col != '0)};
          if ((item_last_row || (item_row != '0)) &&
              (item_col_end || (item_col != '0))) begin
            state <= S_SUM;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SUM: begin
          pending <= pending & ~low_bit;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (result_load) begin
            state <= sum_last ? S_IDLE : S_SUM;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_pixel    <= rgb_t'(pixel_word);
      item_row      <= row_count;
      item_col      <= column_count;
      item_col_end  <= col_end_now;
      item_last_row <= last_row_now;
    end
    if (state == S_SUM) begin
      sum_red       <= acc_red;
      sum_green     <= acc_green;
      sum_blue      <= acc_blue;
      sum_count     <= COUNT_W'($countones(incl));
      sum_row       <= kind[1] ? item_row : item_row - ROW_W'(1);
      sum_col       <= kind[0] ? item_col : item_col - COL_W'(1);
      sum_last      <= ((pending & ~low_bit) == 4'b0000);
      sum_frame_end <= (kind == 2'd3);
    end
    if (result_load) begin
      result_word.blurred_red   <= round_mean(sum_red, sum_count);
      result_word.blurred_green <= round_mean(sum_green, sum_count);
      result_word.blurred_blue  <= round_mean(sum_blue, sum_count);
      result_word.out_row       <= OUT_ROW_W'(sum_row);
      result_word.out_column    <= OUT_COL_W'(sum_col);
      result_word.last_of_run   <= sum_last;
      result_word.frame_end     <= sum_frame_end;
    end
  end

endmodule
